@@ rtl/tao_pkg.sv @@
package tao_pkg;

  localparam int SAMPLE_BITS_DEFAULT  = 16;
  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int QUEUE_DEPTH          = 4;

  // Angles inside the CORDIC are held in units of 2^-ANGLE_FRAC degree.
  localparam int ANGLE_FRAC = 20;
  localparam int ZW         = 28;
  localparam int TINT_W     = 7;
  localparam int DEG_W      = 9;

  localparam logic signed [ZW-1:0] DEG90 = ZW'(90) <<< ANGLE_FRAC;

  localparam logic [DEG_W-1:0] DEG_45  = 9'd45;
  localparam logic [DEG_W-1:0] DEG_135 = 9'd135;
  localparam logic [DEG_W-1:0] DEG_179 = 9'd179;
  localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
  localparam logic [DEG_W-1:0] DEG_225 = 9'd225;
  localparam logic [DEG_W-1:0] DEG_315 = 9'd315;
  localparam logic [DEG_W-1:0] DEG_359 = 9'd359;
  localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

  localparam logic [2:0] SCALE_WIDE   = 3'd5;
  localparam logic [2:0] SCALE_NARROW = 3'd3;
  localparam logic [5:0] COL_WIDE     = 6'd40;
  localparam logic [5:0] COL_NARROW   = 6'd25;
  localparam logic [5:0] ROW_WIDE     = 6'd30;
  localparam logic [5:0] ROW_NARROW   = 6'd35;

  typedef enum logic [1:0] {
    ORIENT_TOP    = 2'd0,
    ORIENT_LEFT   = 2'd1,
    ORIENT_BOTTOM = 2'd2,
    ORIENT_RIGHT  = 2'd3
  } orient_t;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_ZERO_Y = 2'd1,
    KIND_ZERO_X = 2'd2
  } kind_t;

  typedef struct packed {
    logic  xneg;
    logic  yneg;
    kind_t kind;
  } tao_class_t;

  // atan(2^-i) in degrees, scaled by 2^ANGLE_FRAC and rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 28'sd47185920;
      5'd1:    v = 28'sd27855475;
      5'd2:    v = 28'sd14718068;
      5'd3:    v = 28'sd7471121;
      5'd4:    v = 28'sd3750058;
      5'd5:    v = 28'sd1876857;
      5'd6:    v = 28'sd938658;
      5'd7:    v = 28'sd469357;
      5'd8:    v = 28'sd234682;
      5'd9:    v = 28'sd117342;
      5'd10:   v = 28'sd58671;
      5'd11:   v = 28'sd29335;
      5'd12:   v = 28'sd14668;
      5'd13:   v = 28'sd7334;
      5'd14:   v = 28'sd3667;
      5'd15:   v = 28'sd1833;
      5'd16:   v = 28'sd917;
      5'd17:   v = 28'sd458;
      5'd18:   v = 28'sd229;
      5'd19:   v = 28'sd115;
      5'd20:   v = 28'sd57;
      5'd21:   v = 28'sd29;
      5'd22:   v = 28'sd14;
      5'd23:   v = 28'sd7;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/tao_front.sv @@
module tao_front import tao_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  output logic                          q_push,
  input  logic                          q_full,
  output logic [SAMPLE_BITS-1:0]        mag_x,
  output logic [SAMPLE_BITS-1:0]        mag_y,
  output tao_class_t                    cls
);

  logic                   fvalid;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] ax_abs;
  logic [SAMPLE_BITS-1:0] ay_abs;
  tao_class_t             cls_next;

  assign full   = fvalid && q_full;
  assign accept = push && !full;
  assign q_push = fvalid && !q_full;

  // The magnitude of the most negative sample still fits as an unsigned value.
  always_comb begin
    logic signed [SAMPLE_BITS:0] xe;
    logic signed [SAMPLE_BITS:0] ye;
    xe = (SAMPLE_BITS+1)'(accel_x);
    ye = (SAMPLE_BITS+1)'(accel_y);
    ax_abs = accel_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-xe) : SAMPLE_BITS'(xe);
    ay_abs = accel_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ye) : SAMPLE_BITS'(ye);
    cls_next.xneg = accel_x[SAMPLE_BITS-1];
    cls_next.yneg = accel_y[SAMPLE_BITS-1];
    if (accel_y == '0) begin
      cls_next.kind = KIND_ZERO_Y;
    end else if (accel_x == '0) begin
      cls_next.kind = KIND_ZERO_X;
    end else begin
      cls_next.kind = KIND_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (q_push) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_x <= ax_abs;
      mag_y <= ay_abs;
      cls   <= cls_next;
    end
  end

endmodule

@@ rtl/tao_queue.sv @@
module tao_queue import tao_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ rtl/tao_cordic.sv @@
module tao_cordic import tao_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] mag_x,
  input  logic [SAMPLE_BITS-1:0] mag_y,
  input  tao_class_t             in_cls,
  output logic                   out_valid,
  output logic signed [ZW-1:0]   out_z,
  output tao_class_t             out_cls
);

  // The vector grows by about 1.65 over the iterations, so two extra bits suffice.
  localparam int XW = SAMPLE_BITS + 2;

  // Entry i holds the registered output of iteration i.
  logic signed [XW-1:0] xs  [CORDIC_STEPS];
  logic signed [XW-1:0] ys  [CORDIC_STEPS];
  logic signed [ZW-1:0] zs  [CORDIC_STEPS];
  tao_class_t           cs  [CORDIC_STEPS];
  logic                 vs  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    tao_class_t           c_in;
    logic                 v_in;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    logic                 ypos;

    if (i == 0) begin : g_head
      assign x_in = XW'(mag_x);
      assign y_in = XW'(mag_y);
      assign z_in = '0;
      assign c_in = in_cls;
      assign v_in = in_valid;
    end else begin : g_link
      assign x_in = xs[i-1];
      assign y_in = ys[i-1];
      assign z_in = zs[i-1];
      assign c_in = cs[i-1];
      assign v_in = vs[i-1];
    end

    assign dx   = y_in >>> i;
    assign dy   = x_in >>> i;
    assign da   = atan_entry(5'(i));
    assign ypos = !y_in[XW-1] && (y_in != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i] <= 1'b0;
      end else if (en) begin
        vs[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (ypos) begin
          xs[i] <= x_in + dx;
          ys[i] <= y_in - dy;
          zs[i] <= z_in + da;
        end else begin
          xs[i] <= x_in - dx;
          ys[i] <= y_in + dy;
          zs[i] <= z_in - da;
        end
        cs[i] <= c_in;
      end
    end
  end

  assign out_valid = vs[CORDIC_STEPS-1];
  assign out_z     = zs[CORDIC_STEPS-1];
  assign out_cls   = cs[CORDIC_STEPS-1];

endmodule

@@ rtl/tilt_angle_orientation.sv @@
// Tilt angle and display orientation from an accelerometer x/y sample. Each item gives
// one result: the angle |atan2(y,x) - 180 degrees| truncated to whole degrees (0..359),
// the display orientation that angle falls in, and the text scale and cursor position
// for it. The block takes one item every cycle and sustains that rate as long as results
// are popped. An item passes through the input register, a four-entry queue and the
// CORDIC pipeline, which spends one stage per iteration, followed by the result register.
// When results are not taken the pipeline holds; the queue fills its four entries and the
// input register holds one more item before full rises.
module tilt_angle_orientation import tao_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  output logic                          empty,
  input  logic                          pop,
  output logic [8:0]                    angle_degrees,
  output logic [1:0]                    orientation,
  output logic [2:0]                    text_scale,
  output logic [5:0]                    cursor_col,
  output logic [5:0]                    cursor_row
);

  localparam int QW = $bits(tao_class_t) + 2*SAMPLE_BITS;

  logic                   q_push;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;
  logic [SAMPLE_BITS-1:0] f_mag_x;
  logic [SAMPLE_BITS-1:0] f_mag_y;
  tao_class_t             f_cls;
  logic [QW-1:0]          q_din;
  logic [QW-1:0]          q_dout;
  logic [SAMPLE_BITS-1:0] h_mag_x;
  logic [SAMPLE_BITS-1:0] h_mag_y;
  tao_class_t             h_cls;

  logic                   en;
  logic                   c_valid;
  logic signed [ZW-1:0]   c_z;
  tao_class_t             c_cls;

  logic                   out_valid;
  logic [ZW-1:0]          t_clamped;
  logic [TINT_W-1:0]      t_int;
  logic [DEG_W-1:0]       t_ext;
  logic                   t_frac;
  logic [DEG_W-1:0]       deg_next;
  orient_t                orient_next;
  logic                   wide;

  tao_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .q_push (q_push),
    .q_full (q_full),
    .mag_x  (f_mag_x),
    .mag_y  (f_mag_y),
    .cls    (f_cls)
  );

  assign q_din = {f_cls, f_mag_x, f_mag_y};

  tao_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign {h_cls, h_mag_x, h_mag_y} = q_dout;

  // The whole back end moves together whenever the result register is free or being emptied.
  assign en    = !out_valid || pop;
  assign q_pop = en && !q_empty;

  tao_cordic #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (!q_empty),
    .mag_x    (h_mag_x),
    .mag_y    (h_mag_y),
    .in_cls   (h_cls),
    .out_valid(c_valid),
    .out_z    (c_z),
    .out_cls  (c_cls)
  );

  // First-quadrant angle: exact on an axis, otherwise the clamped CORDIC sum.
  always_comb begin
    case (c_cls.kind)
      KIND_ZERO_Y: t_clamped = '0;
      KIND_ZERO_X: t_clamped = DEG90;
      default: begin
        if (c_z[ZW-1]) begin
          t_clamped = '0;
        end else if (c_z > DEG90) begin
          t_clamped = DEG90;
        end else begin
          t_clamped = c_z;
        end
      end
    endcase
  end

  assign t_int  = t_clamped[ANGLE_FRAC +: TINT_W];
  assign t_frac = |t_clamped[ANGLE_FRAC-1:0];
  assign t_ext  = DEG_W'(t_int);

  // Subtracting a fractional angle from a whole number borrows one degree on truncation.
  always_comb begin
    case ({c_cls.xneg, c_cls.yneg})
      2'b00:   deg_next = t_frac ? DEG_179 - t_ext : DEG_180 - t_ext;
      2'b10:   deg_next = t_ext;
      2'b11: begin
        if (t_frac) begin
          deg_next = DEG_359 - t_ext;
        end else if (t_ext == '0) begin
          deg_next = DEG_359;
        end else begin
          deg_next = DEG_360 - t_ext;
        end
      end
      default: deg_next = DEG_180 + t_ext;
    endcase
  end

  always_comb begin
    if (deg_next < DEG_45 || deg_next >= DEG_315) begin
      orient_next = ORIENT_RIGHT;
    end else if (deg_next < DEG_135) begin
      orient_next = ORIENT_TOP;
    end else if (deg_next < DEG_225) begin
      orient_next = ORIENT_LEFT;
    end else begin
      orient_next = ORIENT_BOTTOM;
    end
    wide = (orient_next == ORIENT_RIGHT) || (orient_next == ORIENT_LEFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_degrees <= deg_next;
      orientation   <= orient_next;
      text_scale    <= wide ? SCALE_WIDE : SCALE_NARROW;
      cursor_col    <= wide ? COL_WIDE : COL_NARROW;
      cursor_row    <= wide ? ROW_WIDE : ROW_NARROW;
    end
  end

  assign empty = !out_valid;

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> angle_degrees < DEG_360)
    else $error("angle out of range");

  a_scale_matches: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((orientation == ORIENT_RIGHT || orientation == ORIENT_LEFT)
                == (text_scale == SCALE_WIDE)))
    else $error("text scale does not match orientation");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push into a full queue");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(angle_degrees)))
    else $error("result changed while stalled");

endmodule

@@ tb/tilt_angle_orientation_tb.sv @@
module tilt_angle_orientation_tb;
  import tao_pkg::*;

  localparam int SAMPLE_W     = SAMPLE_BITS_DEFAULT;
  localparam int TURN_STEPS   = (CORDIC_STEPS_DEFAULT < 24) ? CORDIC_STEPS_DEFAULT : 24;
  localparam int PIPE_LATENCY = CORDIC_STEPS_DEFAULT + 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_PER_PHASE = 416;

  typedef struct packed {
    logic [8:0] angle;
    orient_t    orient;
    logic [2:0] scale;
    logic [5:0] col;
    logic [5:0] row;
  } tilt_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [SAMPLE_W-1:0] accel_x = '0;
  logic signed [SAMPLE_W-1:0] accel_y = '0;
  logic full;
  logic empty;
  logic [8:0] angle_degrees;
  logic [1:0] orientation;
  logic [2:0] text_scale;
  logic [5:0] cursor_col;
  logic [5:0] cursor_row;

  tilt_view_t expected_views[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int orient_seen[4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  // atan(2^-i) in degrees, in units of 2^-20 degree.
  longint atan_step_fx[0:23] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  tilt_angle_orientation dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .empty(empty),
    .pop(pop),
    .angle_degrees(angle_degrees),
    .orientation(orientation),
    .text_scale(text_scale),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_views.size());
      $display("tilt_angle_orientation: mismatch");
      $finish;
    end
  end

  // Works out the tilt angle by vectoring |x|,|y| onto the x axis, then the display
  // setup for the orientation sector that the angle falls in.
  function automatic tilt_view_t predict_tilt(input logic signed [SAMPLE_W-1:0] sx,
                                              input logic signed [SAMPLE_W-1:0] sy);
    tilt_view_t view;
    longint vx, vy, acc, dx, dy, tilt, ang, deg;
    logic wide;
    vx = (sx < 0) ? -longint'(sx) : longint'(sx);
    vy = (sy < 0) ? -longint'(sy) : longint'(sy);
    acc = 0;
    if (vy == 0) begin
      tilt = 0;
    end else if (vx == 0) begin
      tilt = longint'(90) <<< ANGLE_FRAC;
    end else begin
      for (int i = 0; i < TURN_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy > 0) begin
          vx = vx + dx;
          vy = vy - dy;
          acc = acc + atan_step_fx[i];
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          acc = acc - atan_step_fx[i];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(90) <<< ANGLE_FRAC)) acc = longint'(90) <<< ANGLE_FRAC;
      tilt = acc;
    end
    if (sx >= 0 && sy >= 0) ang = (longint'(180) <<< ANGLE_FRAC) - tilt;
    else if (sx < 0 && sy >= 0) ang = tilt;
    else if (sx < 0) ang = (longint'(360) <<< ANGLE_FRAC) - tilt;
    else ang = (longint'(180) <<< ANGLE_FRAC) + tilt;
    if (ang < 0) ang = 0;
    if (ang > (longint'(360) <<< ANGLE_FRAC) - 1) ang = (longint'(360) <<< ANGLE_FRAC) - 1;
    deg = ang >>> ANGLE_FRAC;
    view.angle = deg[8:0];
    if (view.angle < DEG_45 || view.angle >= DEG_315) begin
      view.orient = ORIENT_RIGHT;
      wide = 1'b1;
    end else if (view.angle < DEG_135) begin
      view.orient = ORIENT_TOP;
      wide = 1'b0;
    end else if (view.angle < DEG_225) begin
      view.orient = ORIENT_LEFT;
      wide = 1'b1;
    end else begin
      view.orient = ORIENT_BOTTOM;
      wide = 1'b0;
    end
    view.scale = wide ? SCALE_WIDE : SCALE_NARROW;
    view.col = wide ? COL_WIDE : COL_NARROW;
    view.row = wide ? ROW_WIDE : ROW_NARROW;
    return view;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sx,
                             input logic signed [SAMPLE_W-1:0] sy);
    tilt_view_t view;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    accel_x <= sx;
    accel_y <= sy;
    @(posedge clk);
    while (full) @(posedge clk);
    view = predict_tilt(sx, sy);
    expected_views.push_back(view);
    orient_seen[view.orient]++;
    samples_sent++;
  endtask

  always @(posedge clk) begin
    tilt_view_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result with nothing expected, actual angle %0d orientation %0d",
                   $time, angle_degrees, orientation);
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          results_checked++;
          if (angle_degrees !== want.angle) begin
            $display("%0t: angle_degrees expected %0d actual %0d",
                     $time, want.angle, angle_degrees);
            mismatch_count++;
          end
          if (orientation !== want.orient) begin
            $display("%0t: orientation expected %0d actual %0d",
                     $time, want.orient, orientation);
            mismatch_count++;
          end
          if (text_scale !== want.scale) begin
            $display("%0t: text_scale expected %0d actual %0d",
                     $time, want.scale, text_scale);
            mismatch_count++;
          end
          if (cursor_col !== want.col) begin
            $display("%0t: cursor_col expected %0d actual %0d",
                     $time, want.col, cursor_col);
            mismatch_count++;
          end
          if (cursor_row !== want.row) begin
            $display("%0t: cursor_row expected %0d actual %0d",
                     $time, want.row, cursor_row);
            mismatch_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Samples on an axis, including the origin, where the arctangent is short-circuited.
  task automatic test_axis_cases();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd0, 16'sd32767);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd0, -16'sd32768);
  endtask

  // Range extremes and diagonals in all four quadrants.
  task automatic test_extremes();
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd32767, 16'sd1);
    send_sample(-16'sd32768, -16'sd1);
    send_sample(16'sd1, -16'sd32768);
    send_sample(-16'sd1000, 16'sd1000);
    send_sample(16'sd1000, -16'sd1001);
  endtask

  task automatic test_random_samples(input int count);
    logic signed [SAMPLE_W-1:0] sx, sy;
    logic signed [SAMPLE_W-1:0] corner[6];
    int mag;
    corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          sx = SAMPLE_W'($urandom);
          sy = SAMPLE_W'($urandom);
        end
        4: begin
          sx = SAMPLE_W'($urandom_range(16) - 8);
          sy = SAMPLE_W'($urandom_range(16) - 8);
        end
        5: begin
          sx = SAMPLE_W'($urandom);
          sy = '0;
          if ($urandom_range(1)) begin
            sy = sx;
            sx = '0;
          end
        end
        6: begin
          sx = corner[$urandom_range(5)];
          sy = corner[$urandom_range(5)];
        end
        7: begin
          // Close to a diagonal, where the orientation boundaries lie.
          mag = $urandom_range(30000);
          sx = $urandom_range(1) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
          mag = mag + $urandom_range(6) - 3;
          sy = $urandom_range(1) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
        end
        default: begin
          sx = SAMPLE_W'($urandom_range(2046) - 1023);
          sy = SAMPLE_W'($urandom_range(2046) - 1023);
        end
      endcase
      send_sample(sx, sy);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 69;
    test_axis_cases();
    test_extremes();
    test_random_samples(RANDOM_PER_PHASE);

    send_idle_pct = 69;
    recv_idle_pct = 6;
    test_random_samples(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_samples(RANDOM_PER_PHASE);
    push <= 1'b0;

    while (expected_views.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    $display("Sent %0d samples and checked %0d results across three idling mixes.",
             samples_sent, results_checked);
    $display("Orientations: top %0d, left %0d, bottom %0d, right %0d.",
             orient_seen[ORIENT_TOP], orient_seen[ORIENT_LEFT],
             orient_seen[ORIENT_BOTTOM], orient_seen[ORIENT_RIGHT]);
    if (mismatch_count == 0 && expected_views.size() == 0) begin
      $display("tilt_angle_orientation: match");
    end else begin
      $display("tilt_angle_orientation: mismatch");
    end
    $finish;
  end

endmodule
